// ===== sv/frdc_pkg.sv =====
// frdc_pkg: types, codes and helper functions for the frame receiver core
// no dependencies; used by the channel interfaces and the top level

package frdc_pkg;

  localparam int BYTE_W      = 8;
  localparam int DATA_W      = 24;
  localparam int KIND_W      = 2;
  localparam int PTYPE_W     = 2;
  localparam int REG_IDX_W   = 3;
  localparam int LIMIT_W     = 5;
  localparam int FRAME_BYTES = 8;
  localparam int WINDOW_DEPTH = 7;

  // register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_HEADER_FIRST   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEADER_SECOND  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TRAILER_FIRST  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TRAILER_SECOND = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CHECKSUM_MASK  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_RUN_LIMIT = 3'd5;

  // register reset values
  localparam logic [BYTE_W-1:0]  CHECKSUM_MASK_RST  = 8'h3F;
  localparam logic [LIMIT_W-1:0] ZERO_RUN_LIMIT_RST = 5'd10;

  // event kinds
  localparam logic [KIND_W-1:0] EV_ACK = 2'd0;
  localparam logic [KIND_W-1:0] EV_DUP = 2'd1;
  localparam logic [KIND_W-1:0] EV_NEW = 2'd2;

  // packet types
  localparam logic [PTYPE_W-1:0] PT_NONE = 2'd0;
  localparam logic [PTYPE_W-1:0] PT_CMD  = 2'd1;
  localparam logic [PTYPE_W-1:0] PT_KFS  = 2'd2;

  localparam logic [BYTE_W-1:0] NIBBLE_LO = 8'h0F;
  localparam logic [BYTE_W-1:0] NIBBLE_HI = 8'hF0;

  typedef struct packed {
    logic [KIND_W-1:0]  event_kind;
    logic               send_ack;
    logic [DATA_W-1:0]  frame_data;
    logic               frame_parity;
    logic [PTYPE_W-1:0] packet_type;
    logic [BYTE_W-1:0]  item_first;
    logic [BYTE_W-1:0]  item_second;
    logic [BYTE_W-1:0]  item_third;
  } result_t;

  // masked checksum: inverted low byte of the squared data sum
  // only the low byte of the sum matters for the low byte of the square
  function automatic logic [BYTE_W-1:0] check_of(input logic [BYTE_W-1:0] d0,
                                                 input logic [BYTE_W-1:0] d1,
                                                 input logic [BYTE_W-1:0] d2,
                                                 input logic [BYTE_W-1:0] mask);
    logic [BYTE_W+1:0]   sum;
    logic [BYTE_W-1:0]   sum_lo;
    logic [2*BYTE_W-1:0] sq;
    sum    = {2'b00, d0} + {2'b00, d1} + {2'b00, d2};
    sum_lo = sum[BYTE_W-1:0];
    sq     = {8'h00, sum_lo} * {8'h00, sum_lo};
    return ~sq[BYTE_W-1:0] & mask;
  endfunction

  // bit k set when the word holds a run of at least k+1 zero bits
  function automatic logic [DATA_W-1:0] zero_runs(input logic [DATA_W-1:0] d);
    logic [DATA_W-1:0] z;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] runs;
    z    = ~d;
    runs = '0;
    for (int n = 1; n <= DATA_W; n++) begin
      m = {DATA_W{1'b1}} >> (DATA_W - n);
      for (int i = 0; i <= DATA_W - n; i++) begin
        if (((z >> i) & m) == m) begin
          runs[n-1] = 1'b1;
        end
      end
    end
    return runs;
  endfunction

endpackage

// ===== sv/frdc_in_if.sv =====
// frdc_in_if: valid/ready channel carrying received bytes
// depends on frdc_pkg for field widths

interface frdc_in_if;
  logic                          valid;
  logic                          ready;
  logic [frdc_pkg::BYTE_W-1:0]   rx_byte;
  logic                          buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

// ===== sv/frdc_out_if.sv =====
// frdc_out_if: valid/ready channel carrying frame events
// depends on frdc_pkg for field widths

interface frdc_out_if;
  logic                          valid;
  logic                          ready;
  logic [frdc_pkg::KIND_W-1:0]   event_kind;
  logic                          send_ack;
  logic [frdc_pkg::DATA_W-1:0]   frame_data;
  logic                          frame_parity;
  logic [frdc_pkg::PTYPE_W-1:0]  packet_type;
  logic [frdc_pkg::BYTE_W-1:0]   item_first;
  logic [frdc_pkg::BYTE_W-1:0]   item_second;
  logic [frdc_pkg::BYTE_W-1:0]   item_third;

  modport source (output valid, output event_kind, output send_ack, output frame_data,
                  output frame_parity, output packet_type, output item_first,
                  output item_second, output item_third, input ready);
  modport sink   (input valid, input event_kind, input send_ack, input frame_data,
                  input frame_parity, input packet_type, input item_first,
                  input item_second, input item_third, output ready);
endinterface

// ===== sv/frame_receiver_dedup_classify_core.sv =====
// frame_receiver_dedup_classify_core: byte-stream frame receiver top level
// depends on frdc_pkg, frdc_in_if and frdc_out_if
//
// usage
//   rx carries one received byte per transaction with buffer_end marking the
//   last byte of a buffer. res carries at most one transaction per buffer,
//   issued after its last byte: acknowledge, duplicate or new frame, with a
//   new frame classified as command, packed nibbles, raw bytes or none.
//   cfg_we/cfg_index/cfg_data write the header, trailer, checksum mask and
//   zero-run limit registers; write them only while the block is idle.
// pipeline and throughput
//   a byte is captured in the input register and checked against the
//   seven-byte window from there; as it moves on, the result register loads:
//   res valid rises once the last byte has passed through the input register
//   and the result register. one byte per cycle sustained while res is not
//   stalled; the rate is set by the single window/checksum/classify stage.
// reset
//   rst (synchronous) empties both registers, clears the byte count, the
//   found flag and the last accepted data/parity, and loads register defaults.
// stalls
//   while a result waits with res ready low, any byte in the input register is
//   held, so rx.ready drops as soon as the input register is occupied.

module frame_receiver_dedup_classify_core #(
  parameter int MAX_BUFFER_BYTES = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  frdc_in_if.sink                          rx,
  frdc_out_if.source                       res,
  input  logic                             cfg_we,
  input  logic [frdc_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [frdc_pkg::BYTE_W-1:0]      cfg_data
);

  // byte count saturates at MAX_BUFFER_BYTES + 1
  localparam int CNT_W = $clog2(MAX_BUFFER_BYTES + 2);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_BUFFER_BYTES);
  localparam logic [CNT_W-1:0] CNT_FRAME = CNT_W'(frdc_pkg::FRAME_BYTES);
  localparam int BW = frdc_pkg::BYTE_W;
  localparam int DW = frdc_pkg::DATA_W;

  // configuration registers
  logic [BW-1:0] header_first;
  logic [BW-1:0] header_second;
  logic [BW-1:0] trailer_first;
  logic [BW-1:0] trailer_second;
  logic [BW-1:0] checksum_mask;
  logic [frdc_pkg::LIMIT_W-1:0] zero_run_limit;

  // input register
  logic          s1_valid;
  logic [BW-1:0] s1_byte;
  logic          s1_last;
  logic          s1_fire;

  // buffer state
  logic [BW-1:0]    win [frdc_pkg::WINDOW_DEPTH];
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             found;
  logic [DW-1:0]    found_data;
  logic             found_parity;
  logic [DW-1:0]    prev_data;
  logic             prev_parity;

  // result register
  logic                res_valid;
  frdc_pkg::result_t   res_q;
  frdc_pkg::result_t   res_next;

  logic          in_range;
  logic          hit;
  logic [DW-1:0] cur_data;
  logic          cur_parity;
  logic          emit;
  logic          is_new;
  logic [DW-1:0] runs;
  logic          raw_ok;
  logic [BW-1:0] d0;
  logic [BW-1:0] d1;
  logic [BW-1:0] d2;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first   <= '0;
      header_second  <= '0;
      trailer_first  <= '0;
      trailer_second <= '0;
      checksum_mask  <= frdc_pkg::CHECKSUM_MASK_RST;
      zero_run_limit <= frdc_pkg::ZERO_RUN_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        frdc_pkg::REG_HEADER_FIRST:   header_first   <= cfg_data;
        frdc_pkg::REG_HEADER_SECOND:  header_second  <= cfg_data;
        frdc_pkg::REG_TRAILER_FIRST:  trailer_first  <= cfg_data;
        frdc_pkg::REG_TRAILER_SECOND: trailer_second <= cfg_data;
        frdc_pkg::REG_CHECKSUM_MASK:  checksum_mask  <= cfg_data;
        frdc_pkg::REG_ZERO_RUN_LIMIT: zero_run_limit <= cfg_data[frdc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the held byte moves on when the result register can take a result
  assign s1_fire  = s1_valid && (!res_valid || res.ready);
  assign rx.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
      s1_last <= rx.buffer_end;
    end
  end

  // byte count with saturation
  assign cnt_next = (cnt <= CNT_MAX) ? cnt + CNT_W'(1) : cnt;
  assign in_range = (cnt_next >= CNT_FRAME) && (cnt_next <= CNT_MAX);

  // frame match over the window plus the current byte (trailer_second)
  assign hit = !found && in_range &&
               (win[0] == header_first) && (win[1] == header_second) &&
               (win[6] == trailer_first) && (s1_byte == trailer_second) &&
               ((win[5] & checksum_mask) ==
                frdc_pkg::check_of(win[2], win[3], win[4], checksum_mask));

  // a frame found on this very byte counts for this buffer's end
  assign cur_data   = found ? found_data : {win[2], win[3], win[4]};
  assign cur_parity = found ? found_parity : win[5][6];
  assign emit       = s1_last && (found || hit) && (cnt_next <= CNT_MAX);

  assign d0     = cur_data[23:16];
  assign d1     = cur_data[15:8];
  assign d2     = cur_data[7:0];
  assign runs   = frdc_pkg::zero_runs(cur_data);
  assign raw_ok = (zero_run_limit >= frdc_pkg::LIMIT_W'(DW)) || !runs[zero_run_limit];
  assign is_new = (cur_data != '0) &&
                  !((cur_data == prev_data) && (cur_parity == prev_parity));

  // event and classification
  always_comb begin
    res_next              = '0;
    res_next.frame_data   = cur_data;
    res_next.frame_parity = cur_parity;
    if (cur_data == '0) begin
      res_next.event_kind = frdc_pkg::EV_ACK;
    end else if (!is_new) begin
      res_next.event_kind = frdc_pkg::EV_DUP;
      res_next.send_ack   = 1'b1;
    end else begin
      res_next.event_kind = frdc_pkg::EV_NEW;
      res_next.send_ack   = 1'b1;
      if ((d0 == '0) && (d1 == '0) && (d2 != '0)) begin
        // command frame
        res_next.packet_type = frdc_pkg::PT_CMD;
        res_next.item_first  = d2;
      end else if (((d1 & frdc_pkg::NIBBLE_LO) == '0) && (d2 == '0)) begin
        // packed nibbles
        res_next.packet_type = frdc_pkg::PT_KFS;
        res_next.item_first  = (d0 & frdc_pkg::NIBBLE_HI) >> 4;
        res_next.item_second = d0 & frdc_pkg::NIBBLE_LO;
        res_next.item_third  = (d1 & frdc_pkg::NIBBLE_HI) >> 4;
      end else if (raw_ok) begin
        // raw bytes
        res_next.packet_type = frdc_pkg::PT_KFS;
        res_next.item_first  = d0;
        res_next.item_second = d1;
        res_next.item_third  = d2;
      end
    end
  end

  // buffer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      found       <= 1'b0;
      prev_data   <= '0;
      prev_parity <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last) begin
        cnt   <= '0;
        found <= 1'b0;
      end else begin
        cnt <= cnt_next;
        if (hit) begin
          found <= 1'b1;
        end
      end
      if (emit && is_new) begin
        prev_data   <= cur_data;
        prev_parity <= cur_parity;
      end
    end
  end

  // window shift and captured frame
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      for (int k = 0; k < frdc_pkg::WINDOW_DEPTH - 1; k++) begin
        win[k] <= win[k+1];
      end
      win[frdc_pkg::WINDOW_DEPTH-1] <= s1_byte;
      if (hit) begin
        found_data   <= {win[2], win[3], win[4]};
        found_parity <= win[5][6];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && emit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      res_q <= res_next;
    end
  end

  assign res.valid        = res_valid;
  assign res.event_kind   = res_q.event_kind;
  assign res.send_ack     = res_q.send_ack;
  assign res.frame_data   = res_q.frame_data;
  assign res.frame_parity = res_q.frame_parity;
  assign res.packet_type  = res_q.packet_type;
  assign res.item_first   = res_q.item_first;
  assign res.item_second  = res_q.item_second;
  assign res.item_third   = res_q.item_third;

  // byte count never passes its saturation value
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_MAX + CNT_W'(1))
    else $error("byte count beyond saturation");

  // a buffer end always clears the count and found flag
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> (cnt == '0) && !found)
    else $error("buffer end did not clear state");

  // a new result only follows a processed buffer end
  a_res_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s1_fire && s1_last))
    else $error("result without buffer end");

  // acknowledges carry zero data and request no ack
  a_ack_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_q.event_kind == frdc_pkg::EV_ACK) |->
      (res_q.frame_data == '0) && !res_q.send_ack &&
      (res_q.packet_type == frdc_pkg::PT_NONE))
    else $error("malformed acknowledge result");

  // after a new frame is issued it becomes the duplicate reference
  a_new_stored: assert property (@(posedge clk) disable iff (rst)
    s1_fire && emit && is_new |=>
      (prev_data == $past(cur_data)) && (prev_parity == $past(cur_parity)))
    else $error("new frame not stored");

endmodule
